/* rtl/core/cpio_newc_archive_parser_defines.svh */
// Assertion macros shared by the cpio newc parser modules.
// No dependencies.
`ifndef CPIO_NEWC_ARCHIVE_PARSER_DEFINES_SVH
`define CPIO_NEWC_ARCHIVE_PARSER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CPIO_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpio assertion failed");
// Next-cycle implication checked outside reset.
`define CPIO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpio assertion failed");
`endif

/* rtl/core/cpio_pkg.sv */
// Types, constants and helpers of the cpio newc parser.
// Used by all modules in rtl/core; no dependencies.
package cpio_pkg;
	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_NAME     = 3'd1,
		PH_NAME_PAD = 3'd2,
		PH_DATA     = 3'd3,
		PH_DATA_PAD = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		K_NAME    = 3'd0,
		K_DATA    = 3'd1,
		K_ENTRY   = 3'd2,
		K_TRAILER = 3'd3,
		K_BAD_MAG = 3'd4,
		K_BAD_HEX = 3'd5
	} kind_t;

	localparam logic [6:0] HDR_LAST = 7'd109;
	localparam logic [6:0] MODE_AT  = 7'd14;
	localparam logic [6:0] SIZE_AT  = 7'd54;
	localparam logic [6:0] NSIZE_AT = 7'd94;
	localparam int QDEPTH = 2;

	// One result item as it travels through the queue.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_value;
		logic [2:0]  file_type;
		logic [8:0]  permissions;
		logic [31:0] file_size;
		logic [31:0] name_length;
		logic [31:0] data_offset;
		logic        last_of_name;
	} result_t;

	function automatic logic [7:0] magic_char(input logic [2:0] i);
		unique case (i)
			3'd0, 3'd2, 3'd4: magic_char = 8'h30;
			3'd1, 3'd3:       magic_char = 8'h37;
			3'd5:             magic_char = 8'h31;
			default:          magic_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] trailer_char(input logic [3:0] i);
		unique case (i)
			4'd0: trailer_char = 8'h54;
			4'd1: trailer_char = 8'h52;
			4'd2: trailer_char = 8'h41;
			4'd3: trailer_char = 8'h49;
			4'd4: trailer_char = 8'h4C;
			4'd5: trailer_char = 8'h45;
			4'd6: trailer_char = 8'h52;
			default: trailer_char = 8'h21;
		endcase
	endfunction

	function automatic logic [2:0] type_class(input logic [3:0] fmt);
		unique case (fmt)
			4'o14:   type_class = 3'd0;
			4'o12:   type_class = 3'd1;
			4'o06:   type_class = 3'd3;
			4'o04:   type_class = 3'd4;
			4'o02:   type_class = 3'd5;
			4'o01:   type_class = 3'd6;
			default: type_class = 3'd2;
		endcase
	endfunction
endpackage

/* rtl/core/cpio_front.sv */
// Front part: accepts archive bytes, tracks the parse state and builds results.
// Depends on cpio_pkg and cpio_newc_archive_parser_defines.svh.
module cpio_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       archive_byte,
	input  logic             restart,
	input  logic             take,
	output logic             res_valid,
	output cpio_pkg::result_t res
);
	cpio_pkg::phase_t phase_q, phase_d;
	logic [6:0]  hidx_q, hidx_d;
	logic [31:0] mode_q, mode_d, size_q, size_d, nsize_q, nsize_d;
	logic [31:0] left_q, left_d, off_q, off_d;
	logic [1:0]  pad_q, pad_d;
	logic        tmatch_q, tmatch_d, stop_q, stop_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cpio_pkg::PH_HEADER;
			hidx_q   <= '0;
			mode_q   <= '0;
			size_q   <= '0;
			nsize_q  <= '0;
			left_q   <= '0;
			off_q    <= '0;
			pad_q    <= '0;
			tmatch_q <= 1'b1;
			stop_q   <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			hidx_q   <= hidx_d;
			mode_q   <= mode_d;
			size_q   <= size_d;
			nsize_q  <= nsize_d;
			left_q   <= left_d;
			off_q    <= off_d;
			pad_q    <= pad_d;
			tmatch_q <= tmatch_d;
			stop_q   <= stop_d;
		end
	end

	logic [7:0] b;
	logic [3:0] nib;
	logic       nib_ok;
	logic [31:0] pos;
	logic [1:0]  npad;
	assign b = archive_byte;

	always_comb begin
		nib_ok = 1'b1;
		nib    = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) nib = b[3:0];
		else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
			nib = b[3:0] + 4'd9;
		else nib_ok = 1'b0;
	end

	always_comb begin
		cpio_pkg::phase_t ph;
		logic [6:0] hi;
		logic [31:0] ns, sz, md, lf;
		logic tm, fin;
		phase_d = phase_q; hidx_d = hidx_q; mode_d = mode_q; size_d = size_q;
		nsize_d = nsize_q; left_d = left_q; off_d = off_q; pad_d = pad_q;
		tmatch_d = tmatch_q; stop_d = stop_q;
		res = '0;
		res_valid = 1'b0;
		fin = 1'b0;
		pos = '0;
		npad = '0;
		if (restart) begin
			phase_d = cpio_pkg::PH_HEADER; hidx_d = '0; mode_d = '0; size_d = '0;
			nsize_d = '0; left_d = '0; off_d = '0; pad_d = '0;
			tmatch_d = 1'b1; stop_d = 1'b0;
		end
		ph = phase_d; hi = hidx_d; md = mode_d; sz = size_d; ns = nsize_d;
		lf = left_d; tm = tmatch_d;
		if (in_valid && !stop_d) begin
			off_d = off_d + 32'd1;
			unique case (ph)
				cpio_pkg::PH_HEADER: begin
					if (hi < 7'd6) begin
						if (b != cpio_pkg::magic_char(hi[2:0])) begin
							stop_d = 1'b1;
							res_valid = 1'b1;
							res.kind = cpio_pkg::K_BAD_MAG;
						end
					end else if ((hi >= cpio_pkg::MODE_AT && hi < cpio_pkg::MODE_AT + 7'd8)
							|| (hi >= cpio_pkg::SIZE_AT && hi < cpio_pkg::SIZE_AT + 7'd8)
							|| (hi >= cpio_pkg::NSIZE_AT && hi < cpio_pkg::NSIZE_AT + 7'd8)) begin
						if (!nib_ok) begin
							stop_d = 1'b1;
							res_valid = 1'b1;
							res.kind = cpio_pkg::K_BAD_HEX;
						end else if (hi < cpio_pkg::MODE_AT + 7'd8) begin
							md = {md[27:0], nib};
						end else if (hi < cpio_pkg::SIZE_AT + 7'd8) begin
							sz = {sz[27:0], nib};
						end else begin
							ns = {ns[27:0], nib};
						end
					end
					mode_d = md; size_d = sz; nsize_d = ns;
					if (!res_valid) begin
						if (hi != cpio_pkg::HDR_LAST) begin
							hidx_d = hi + 7'd1;
						end else begin
							hidx_d = '0;
							tm = 1'b1;
							lf = ns;
							if (ns == 32'd0) fin = 1'b1;
							else ph = cpio_pkg::PH_NAME;
						end
					end
				end
				cpio_pkg::PH_NAME: begin
					pos = ns - lf;
					if (pos < 32'd10 && b != cpio_pkg::trailer_char(pos[3:0])) tm = 1'b0;
					lf = lf - 32'd1;
					if (lf == 32'd0) begin
						fin = 1'b1;
					end else begin
						res_valid = 1'b1;
						res.kind = cpio_pkg::K_NAME;
						res.byte_value = b;
					end
				end
				cpio_pkg::PH_NAME_PAD: begin
					pad_d = pad_d - 2'd1;
					if (pad_d == 2'd0) begin
						if (sz == 32'd0) ph = cpio_pkg::PH_HEADER;
						else begin ph = cpio_pkg::PH_DATA; lf = sz; end
					end
				end
				cpio_pkg::PH_DATA: begin
					lf = lf - 32'd1;
					res_valid = 1'b1;
					res.kind = cpio_pkg::K_DATA;
					res.byte_value = b;
					if (lf == 32'd0) begin
						pad_d = 2'd0 - sz[1:0];
						ph = (pad_d != 2'd0) ? cpio_pkg::PH_DATA_PAD : cpio_pkg::PH_HEADER;
						res.last_of_name = 1'b1;
					end
				end
				cpio_pkg::PH_DATA_PAD: begin
					pad_d = pad_d - 2'd1;
					if (pad_d == 2'd0) ph = cpio_pkg::PH_HEADER;
				end
				default: begin
					ph = cpio_pkg::PH_HEADER;
					hidx_d = '0;
				end
			endcase
			if (fin) begin
				res_valid = 1'b1;
				res.last_of_name = 1'b1;
				if (sz == 32'd0 && md == 32'd0 && ns == 32'd11 && tm) begin
					stop_d = 1'b1;
					res.kind = cpio_pkg::K_TRAILER;
				end else begin
					npad = 2'd2 - ns[1:0];
					res.kind = cpio_pkg::K_ENTRY;
					res.file_type = cpio_pkg::type_class(md[15:12]);
					res.permissions = md[8:0];
					res.file_size = sz;
					res.name_length = ns;
					// off_d already points one past this byte, also right after restart.
					res.data_offset = off_d + {30'd0, npad};
					if (npad != 2'd0) begin
						ph = cpio_pkg::PH_NAME_PAD;
						pad_d = npad;
					end else if (sz == 32'd0) begin
						ph = cpio_pkg::PH_HEADER;
					end else begin
						ph = cpio_pkg::PH_DATA;
						lf = sz;
					end
				end
			end
			phase_d = ph; left_d = lf; tmatch_d = tm;
		end
	end

	`include "cpio_newc_archive_parser_defines.svh"
	`CPIO_ASSERT_NEXT(a_stop_holds, take && stop_q && !restart, stop_q)
	`CPIO_ASSERT_IMP(a_hidx_range, 1'b1, hidx_q <= cpio_pkg::HDR_LAST)
	`CPIO_ASSERT_IMP(a_pad_phase, phase_q == cpio_pkg::PH_NAME_PAD, pad_q != 2'd0)
endmodule

/* rtl/core/cpio_queue.sv */
// Short result queue between front and back of the cpio newc parser.
// Depends on cpio_pkg and cpio_newc_archive_parser_defines.svh.
module cpio_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  cpio_pkg::result_t wr_data,
	output logic              full,
	output logic              rd_valid,
	input  logic              rd_en,
	output cpio_pkg::result_t rd_data
);
	cpio_pkg::result_t mem_q [cpio_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'(cpio_pkg::QDEPTH);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	`include "cpio_newc_archive_parser_defines.svh"
	`CPIO_ASSERT_IMP(a_no_overflow, wr_en, !full)
	`CPIO_ASSERT_IMP(a_no_underflow, rd_en, rd_valid)
	`CPIO_ASSERT_IMP(a_count_range, 1'b1, cnt_q <= 2'(cpio_pkg::QDEPTH))
endmodule

/* rtl/core/cpio_back.sv */
// Back part: output register that presents results to the receiver.
// Depends on cpio_pkg and cpio_newc_archive_parser_defines.svh.
module cpio_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cpio_pkg::result_t q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output cpio_pkg::result_t out_data
);
	logic valid_q;
	cpio_pkg::result_t data_q;

	assign q_pop     = q_valid && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (!valid_q || !out_stall) valid_q <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop) data_q <= q_data;
	end

	`include "cpio_newc_archive_parser_defines.svh"
	`CPIO_ASSERT_NEXT(a_hold, valid_q && out_stall, valid_q && $stable(data_q))
	`CPIO_ASSERT_NEXT(a_load, q_pop, valid_q)
endmodule

/* rtl/core/cpio_newc_archive_parser.sv */
// cpio newc archive parser top level: front, result queue and output stage.
// Depends on cpio_pkg, cpio_front, cpio_queue and cpio_back.
//
// Input channel: in_valid/in_stall carry one archive byte and a restart flag
// per item. Restart returns the parser to the archive start before that byte.
// Output channel: out_valid/out_stall carry zero or one result per input
// item: a name or data byte, an entry report, a trailer or an error.
// Throughput is one byte per cycle while the queue is not full; the byte
// counters and hex shift registers of the parse state update as each byte is taken.
// A result enters the two-entry queue at the edge that accepts its byte and
// moves on to the output register once it heads the queue and the register is free.
// When the receiver stalls, the output register holds and the queue fills;
// in_stall is the queue's full flag, so while it is full every byte waits,
// including bytes that make no result.
// Reset clears the parse state to header start and empties the queue; no
// clearing pass is needed.
module cpio_newc_archive_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  archive_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  byte_value,
	output logic [2:0]  file_type,
	output logic [8:0]  permissions,
	output logic [31:0] file_size,
	output logic [31:0] name_length,
	output logic [31:0] data_offset,
	output logic        last_of_name
);
	logic take, res_valid, full, q_valid, q_pop;
	cpio_pkg::result_t res, q_data, o;

	assign in_stall = full;
	assign take     = in_valid && !full;

	cpio_front u_front (
		.clk, .arst_n, .in_valid(take), .archive_byte, .restart, .take,
		.res_valid, .res
	);

	cpio_queue u_queue (
		.clk, .arst_n, .wr_en(take && res_valid), .wr_data(res), .full,
		.rd_valid(q_valid), .rd_en(q_pop), .rd_data(q_data)
	);

	cpio_back u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_pop, .out_valid, .out_stall,
		.out_data(o)
	);

	assign kind         = o.kind;
	assign byte_value   = o.byte_value;
	assign file_type    = o.file_type;
	assign permissions  = o.permissions;
	assign file_size    = o.file_size;
	assign name_length  = o.name_length;
	assign data_offset  = o.data_offset;
	assign last_of_name = o.last_of_name;
endmodule

/* dv/testbench.sv */
// Self-checking testbench for the cpio newc archive parser.
// Depends on cpio_pkg and the cpio_newc_archive_parser top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]  kind;
		logic [7:0]  byte_value;
		logic [2:0]  file_type;
		logic [8:0]  permissions;
		logic [31:0] file_size;
		logic [31:0] name_length;
		logic [31:0] data_offset;
		logic        last_of_name;
	} parse_result_t;

	// Parser state mirror with its own predictor.
	class archive_scoreboard;
		parse_result_t pending[$];
		int errors = 0;
		cpio_pkg::phase_t ph;
		int unsigned hidx;
		logic [31:0] mode_w, size_w, nsize_w, left, offs;
		logic [1:0] pad;
		bit tmatch, halted;

		function new();
			clear();
		endfunction

		function void clear();
			ph = cpio_pkg::PH_HEADER;
			hidx = 0;
			mode_w = 0;
			size_w = 0;
			nsize_w = 0;
			left = 0;
			pad = 0;
			offs = 0;
			tmatch = 1;
			halted = 0;
		endfunction

		function int hexval(logic [7:0] b);
			if (b >= "0" && b <= "9") return b - "0";
			if (b >= "A" && b <= "F") return b - "A" + 10;
			if (b >= "a" && b <= "f") return b - "a" + 10;
			return -1;
		endfunction

		function logic [2:0] class_of(logic [31:0] m);
			case (m[15:12])
				4'o14: return 3'd0;
				4'o12: return 3'd1;
				4'o06: return 3'd3;
				4'o04: return 3'd4;
				4'o02: return 3'd5;
				4'o01: return 3'd6;
				default: return 3'd2;
			endcase
		endfunction

		function logic [7:0] magic_at(int unsigned i);
			string m;
			m = "070701";
			return m[i];
		endfunction

		function void push(logic [2:0] k, logic [7:0] bv, logic last);
			parse_result_t r;
			r = '{k, bv, 3'd0, 9'd0, 32'd0, 32'd0, 32'd0, last};
			pending.push_back(r);
		endfunction

		function void begin_data();
			if (size_w == 0) ph = cpio_pkg::PH_HEADER;
			else begin
				ph = cpio_pkg::PH_DATA;
				left = size_w;
			end
		endfunction

		function void end_of_name(logic [31:0] off);
			parse_result_t r;
			logic [1:0] p;
			if (size_w == 0 && mode_w == 0 && nsize_w == 11 && tmatch) begin
				halted = 1;
				push(cpio_pkg::K_TRAILER, 0, 1);
				return;
			end
			p = 2'(2 - nsize_w);
			if (p != 0) begin
				ph = cpio_pkg::PH_NAME_PAD;
				pad = p;
			end else
				begin_data();
			r = '{cpio_pkg::K_ENTRY, 8'd0, class_of(mode_w), mode_w[8:0], size_w, nsize_w,
				off + 32'd1 + {30'd0, p}, 1'b1};
			pending.push_back(r);
		endfunction

		function void note_input(logic [7:0] b, logic rs);
			logic [31:0] off, pos;
			int nib;
			string tr;
			tr = "TRAILER!!!";
			if (rs) clear();
			if (halted) return;
			off = offs;
			offs = off + 1;
			case (ph)
				cpio_pkg::PH_HEADER: begin
					if (hidx < 6) begin
						if (b != magic_at(hidx)) begin
							halted = 1;
							push(cpio_pkg::K_BAD_MAG, 0, 0);
							return;
						end
					end else if ((hidx >= 14 && hidx < 22) || (hidx >= 54 && hidx < 62) ||
							(hidx >= 94 && hidx < 102)) begin
						nib = hexval(b);
						if (nib < 0) begin
							halted = 1;
							push(cpio_pkg::K_BAD_HEX, 0, 0);
							return;
						end
						if (hidx < 22) mode_w = {mode_w[27:0], 4'(nib)};
						else if (hidx < 62) size_w = {size_w[27:0], 4'(nib)};
						else nsize_w = {nsize_w[27:0], 4'(nib)};
					end
					if (hidx + 1 < 110) begin
						hidx++;
						return;
					end
					hidx = 0;
					tmatch = 1;
					left = nsize_w;
					if (nsize_w == 0) end_of_name(off);
					else ph = cpio_pkg::PH_NAME;
				end
				cpio_pkg::PH_NAME: begin
					pos = nsize_w - left;
					if (pos < 10 && b != tr[pos]) tmatch = 0;
					left--;
					if (left == 0) end_of_name(off);
					else push(cpio_pkg::K_NAME, b, 0);
				end
				cpio_pkg::PH_NAME_PAD: begin
					pad--;
					if (pad == 0) begin_data();
				end
				cpio_pkg::PH_DATA: begin
					left--;
					if (left == 0) begin
						pad = 2'(-size_w);
						ph = (pad != 0) ? cpio_pkg::PH_DATA_PAD : cpio_pkg::PH_HEADER;
						push(cpio_pkg::K_DATA, b, 1);
					end else
						push(cpio_pkg::K_DATA, b, 0);
				end
				default: begin
					pad--;
					if (pad == 0) ph = cpio_pkg::PH_HEADER;
				end
			endcase
		endfunction

		function void check_result(parse_result_t a);
			parse_result_t e;
			if (pending.size() == 0) begin
				$error("result with no expectation, kind %0d", a.kind);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.kind !== e.kind) begin
				$error("kind expected %0d actual %0d", e.kind, a.kind);
				errors++;
			end
			if (a.byte_value !== e.byte_value) begin
				$error("byte_value expected %0h actual %0h", e.byte_value, a.byte_value);
				errors++;
			end
			if (a.file_type !== e.file_type) begin
				$error("file_type expected %0d actual %0d", e.file_type, a.file_type);
				errors++;
			end
			if (a.permissions !== e.permissions) begin
				$error("permissions expected %0o actual %0o", e.permissions, a.permissions);
				errors++;
			end
			if (a.file_size !== e.file_size) begin
				$error("file_size expected %0h actual %0h", e.file_size, a.file_size);
				errors++;
			end
			if (a.name_length !== e.name_length) begin
				$error("name_length expected %0h actual %0h", e.name_length, a.name_length);
				errors++;
			end
			if (a.data_offset !== e.data_offset) begin
				$error("data_offset expected %0h actual %0h", e.data_offset, a.data_offset);
				errors++;
			end
			if (a.last_of_name !== e.last_of_name) begin
				$error("last_of_name expected %0d actual %0d", e.last_of_name, a.last_of_name);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [7:0] archive_byte = 0;
	logic restart = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] kind, file_type;
	logic [7:0] byte_value;
	logic [8:0] permissions;
	logic [31:0] file_size, name_length, data_offset;
	logic last_of_name;

	archive_scoreboard board = new();
	byte unsigned stream_q[$];
	bit restart_q[$];
	int unsigned queued = 0;
	int unsigned cycles = 0;
	int unsigned burst = 0;
	int unsigned hold = 0;

	cpio_newc_archive_parser dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Sender: bursts with random gaps; payload holds while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) board.note_input(archive_byte, restart);
			if (!in_valid || !in_stall) begin
				if (hold > 0) begin
					hold <= hold - 1;
					in_valid <= 0;
				end else if (stream_q.size() > 0) begin
					in_valid <= 1;
					archive_byte <= stream_q.pop_front();
					restart <= restart_q.pop_front();
					if (burst == 0) begin
						burst <= $urandom_range(1, 40);
						if ($urandom_range(0, 2) == 0) hold <= $urandom_range(1, 6);
					end else
						burst <= burst - 1;
				end else
					in_valid <= 0;
			end
		end
	end

	// Receiver: stalls on its own pattern, with quiet stretches.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result('{kind, byte_value, file_type, permissions, file_size,
					name_length, data_offset, last_of_name});
			if (cycles[9]) out_stall <= 0;
			else out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	task automatic put(byte unsigned b, bit rs = 0);
		stream_q.push_back(b);
		restart_q.push_back(rs);
		queued++;
	endtask

	task automatic put_hex(logic [31:0] v);
		string s;
		s = $sformatf("%08h", v);
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 1) && s[i] >= "a") put(8'(s[i] - 8'd32));
			else put(s[i]);
		end
	endtask

	// One entry; corrupt selects 0 clean, 1 bad magic, 2 bad hex digit.
	task automatic put_entry(logic [31:0] mode, logic [31:0] size, logic [31:0] nsize,
			bit trailer, int corrupt, bit rs);
		string tr;
		string mg;
		int badpos;
		tr = "TRAILER!!!";
		mg = "070701";
		badpos = $urandom_range(0, 5);
		for (int i = 0; i < 6; i++)
			put((corrupt == 1 && i == badpos) ? 8'h39 : mg[i], rs && i == 0);
		// The parser ignores everything after a bad magic until restart.
		if (corrupt == 1) return;
		for (int i = 6; i < 14; i++) put(8'($urandom));
		put_hex(mode);
		for (int i = 22; i < 54; i++) put(8'($urandom));
		put_hex(size);
		for (int i = 62; i < 94; i++) put(8'($urandom));
		if (corrupt == 2) begin
			put("g");
			return;
		end
		put_hex(nsize);
		for (int i = 102; i < 110; i++) put(8'($urandom));
		for (int i = 0; i < nsize; i++) put(trailer && i < 10 ? tr[i] : 8'($urandom));
		for (int i = 0; i < ((2 - nsize) & 3); i++) put(8'($urandom));
		for (int i = 0; i < size; i++) put(8'($urandom));
		for (int i = 0; i < ((0 - size) & 3); i++) put(8'($urandom));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		// Directed: extremes of mode, empty name, a trailer, a bad magic, a bad hex digit and restarts.
		put_entry(32'o100777, 0, 0, 0, 0, 0);
		put_entry(32'hFFFFFFFF, 3, 2, 0, 0, 0);
		put_entry(0, 0, 11, 1, 0, 0);
		put(8'hFF);
		put_entry(32'o120644, 1, 3, 0, 2, 1);
		put_entry(0, 0, 0, 0, 1, 1);
		put(8'h00);
		put(8'hAA, 1);
		put_entry(32'o140000, 0, 4, 0, 0, 1);
		// Random archives, mostly well formed.
		while (queued < 640) begin
			put_entry({4'($urandom_range(0, 15)), 12'($urandom)} |
				($urandom_range(0, 9) == 0 ? 32'hFFFF0000 : 32'd0),
				$urandom_range(0, 9), $urandom_range(0, 12),
				$urandom_range(0, 9) == 0, $urandom_range(0, 12) == 0 ?
				$urandom_range(1, 2) : 0, $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0) put(8'($urandom), 1'($urandom_range(0, 1)));
		end
		put_entry(0, 0, 11, 1, 0, 1);
		while (stream_q.size() > 0 || in_valid) @(posedge clk);
		while (board.pending.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cpio_pkg.sv
rtl/core/cpio_front.sv
rtl/core/cpio_queue.sv
rtl/core/cpio_back.sv
rtl/core/cpio_newc_archive_parser.sv
dv/testbench.sv
